>>> sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers that compile away in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property at every rising edge outside of reset.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that the antecedent in one cycle is followed by the consequent in the next.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_AT(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> sv/fsnl_pkg.sv
// ---------------------------------------------------------------------------
// fsnl_pkg
// Types and constants shared by the short-name lookup modules.
// ---------------------------------------------------------------------------
package fsnl_pkg;

  localparam int unsigned KEY_LEN   = 11;
  localparam int unsigned EXT_POS   = 8;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned KEY_W     = 8 * KEY_LEN;

  localparam logic [7:0]  SKIP_MASK = 8'h18;
  localparam logic [7:0]  PAD_BYTE  = 8'h20;
  localparam logic [7:0]  END_BYTE  = 8'h00;
  localparam logic [7:0]  DOT_CHAR  = 8'h2E;
  localparam logic [7:0]  LOWER_A   = 8'h61;
  localparam logic [7:0]  LOWER_Z   = 8'h7A;
  localparam logic [7:0]  CASE_BIT  = 8'h20;

  localparam logic [15:0] MAX_ENTRIES_RESET = 16'd224;

  // Operation codes carried in the op field.
  localparam logic [1:0]  OP_START  = 2'd0;
  localparam logic [1:0]  OP_CHAR   = 2'd1;
  localparam logic [1:0]  OP_ENTRY  = 2'd2;

  typedef enum logic [2:0] {
    OUT_MATCH    = 3'd0,
    OUT_END      = 3'd1,
    OUT_LIMIT    = 3'd2,
    OUT_TOO_LONG = 3'd3,
    OUT_LAST     = 3'd4
  } outcome_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  name_char;
    logic [63:0] entry_base;
    logic [23:0] entry_ext;
    logic [7:0]  entry_attr;
    logic        entry_last;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [15:0] entry_index;
    outcome_e    outcome;
  } out_item_t;

  // Decision for one directory entry, from the match logic to the top level.
  typedef struct packed {
    logic      emit;
    logic      advance;
    out_item_t result;
  } decision_t;

endpackage

>>> sv/fsnl_key.sv
// ---------------------------------------------------------------------------
// fsnl_key
// Holds the 11-byte space-padded upper-case search key and its fill position.
// ---------------------------------------------------------------------------
module fsnl_key
  import fsnl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic             char_en_i,
  input  logic [7:0]       char_i,
  output logic [KEY_W-1:0] key_o,
  output logic             too_long_o
);

  logic [7:0]       key_q [KEY_LEN];
  logic [7:0]       key_d [KEY_LEN];
  logic [POS_W-1:0] pos_q, pos_d;
  logic             too_long_q, too_long_d;
  logic [7:0]       upper_char;

  assign upper_char = ((char_i >= LOWER_A) && (char_i <= LOWER_Z)) ? (char_i & ~CASE_BIT)
                                                                   : char_i;

  always_comb begin
    key_d      = key_q;
    pos_d      = pos_q;
    too_long_d = too_long_q;
    if (clear_i) begin
      for (int i = 0; i < KEY_LEN; i++) begin
        key_d[i] = PAD_BYTE;
      end
      pos_d      = '0;
      too_long_d = 1'b0;
    end else if (char_en_i) begin
      if (pos_q >= POS_W'(KEY_LEN)) begin
        too_long_d = 1'b1;
      end else if ((char_i == DOT_CHAR) && (pos_q <= POS_W'(EXT_POS))) begin
        pos_d = POS_W'(EXT_POS);
      end else begin
        key_d[pos_q] = upper_char;
        pos_d        = pos_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KEY_LEN; i++) begin
        key_q[i] <= PAD_BYTE;
      end
      pos_q      <= '0;
      too_long_q <= 1'b0;
    end else begin
      key_q      <= key_d;
      pos_q      <= pos_d;
      too_long_q <= too_long_d;
    end
  end

  // First key byte sits in the top byte, matching the entry field order.
  always_comb begin
    for (int i = 0; i < KEY_LEN; i++) begin
      key_o[KEY_W-1-8*i -: 8] = key_q[i];
    end
  end

  assign too_long_o = too_long_q;

endmodule

>>> sv/fsnl_match.sv
// ---------------------------------------------------------------------------
// fsnl_match
// Decides the fate of one directory entry against the key and search state.
// ---------------------------------------------------------------------------
module fsnl_match
  import fsnl_pkg::*;
(
  input  in_item_t         item_i,
  input  logic [KEY_W-1:0] key_i,
  input  logic             too_long_i,
  input  logic             done_i,
  input  logic [15:0]      entries_i,
  input  logic [15:0]      max_entries_i,
  output decision_t        dec_o
);

  logic name_equal;
  logic skipped;

  assign name_equal = ({item_i.entry_base, item_i.entry_ext} == key_i);
  assign skipped    = ((item_i.entry_attr & SKIP_MASK) != 8'h00);

  always_comb begin
    dec_o                    = '0;
    dec_o.result.entry_index = entries_i;
    dec_o.result.outcome     = OUT_MATCH;
    if ((item_i.op == OP_ENTRY) && !done_i) begin
      if (too_long_i) begin
        dec_o.emit           = 1'b1;
        dec_o.result.outcome = OUT_TOO_LONG;
      end else if (entries_i >= max_entries_i) begin
        dec_o.emit           = 1'b1;
        dec_o.result.outcome = OUT_LIMIT;
      end else if (item_i.entry_base[63:56] == END_BYTE) begin
        dec_o.emit           = 1'b1;
        dec_o.result.outcome = OUT_END;
      end else if (!skipped && name_equal) begin
        dec_o.emit           = 1'b1;
        dec_o.result.found   = 1'b1;
        dec_o.result.outcome = OUT_MATCH;
      end else begin
        dec_o.advance = 1'b1;
        if (item_i.entry_last) begin
          dec_o.emit               = 1'b1;
          dec_o.result.entry_index = entries_i + 16'd1;
          dec_o.result.outcome     = OUT_LAST;
        end
      end
    end
  end

endmodule

>>> sv/fat_short_name_lookup_unit.sv
// ---------------------------------------------------------------------------
// fat_short_name_lookup_unit
// FAT 8.3 short-name directory lookup: key builder plus entry scanner.
// ---------------------------------------------------------------------------
// A search opens with a start transaction, then name characters build an
// 11-byte space-padded upper-case key, then directory entries are streamed
// in and compared against it one at a time. Each search yields exactly one
// result transaction (match, end marker, entry limit, name too long, or last
// entry unmatched); after that the block ignores entries until the next
// start. The block takes one transaction per clock cycle when not stalled:
// every item is registered at the input and handled in the single decision
// stage that follows, whose critical path is the 88-bit name compare and
// the 16-bit limit compare, and a result is registered in the output
// register as its entry leaves the decision stage. The input is stalled
// only when the decision stage holds an entry that produces a result while
// the output register is full and stalled. The max_entries register is
// written through its own channel, which is always ready, and should be
// written only while the block is idle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fat_short_name_lookup_unit
  import fsnl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Item input channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  // Result output channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o,
  // Configuration write channel for max_entries.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  // Input register stage.
  in_item_t    item_q;
  logic        item_valid_q, item_valid_d;

  // Search state that lives outside the key builder.
  logic [15:0] entries_q, entries_d;
  logic        done_q, done_d;
  logic [15:0] max_entries_q;

  // Result register.
  out_item_t   out_item_q;
  logic        out_valid_q, out_valid_d;

  logic [KEY_W-1:0] key;
  logic             too_long;
  decision_t        dec;

  logic in_accept;
  logic out_free;
  logic stage_fire;
  logic key_clear;
  logic key_char_en;

  // The output register can take a new result when it is empty or being
  // drained in this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  // The staged item moves on unless it needs the output register and that
  // register cannot take it. Items with no result never wait.
  assign stage_fire = item_valid_q && (!dec.emit || out_free);
  assign in_stall_o = item_valid_q && !stage_fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign cfg_ready_o = 1'b1;

  // Characters only count while the search is still building its key, that
  // is before any entry has been scanned and before a result was given.
  assign key_clear   = stage_fire && (item_q.op == OP_START);
  assign key_char_en = stage_fire && (item_q.op == OP_CHAR) && !done_q && (entries_q == 16'd0);

  fsnl_key u_key (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (key_clear),
    .char_en_i  (key_char_en),
    .char_i     (item_q.name_char),
    .key_o      (key),
    .too_long_o (too_long)
  );

  fsnl_match u_match (
    .item_i        (item_q),
    .key_i         (key),
    .too_long_i    (too_long),
    .done_i        (done_q),
    .entries_i     (entries_q),
    .max_entries_i (max_entries_q),
    .dec_o         (dec)
  );

  // Search state update for the item leaving the decision stage.
  always_comb begin
    entries_d = entries_q;
    done_d    = done_q;
    if (stage_fire) begin
      if (item_q.op == OP_START) begin
        entries_d = '0;
        done_d    = 1'b0;
      end else begin
        if (dec.advance) begin
          entries_d = entries_q + 16'd1;
        end
        if (dec.emit) begin
          done_d = 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (in_accept) begin
      item_valid_d = 1'b1;
    end else if (stage_fire) begin
      item_valid_d = 1'b0;
    end else begin
      item_valid_d = item_valid_q;
    end
  end

  always_comb begin
    if (stage_fire && dec.emit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && out_stall_i) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q  <= 1'b0;
      out_valid_q   <= 1'b0;
      entries_q     <= '0;
      done_q        <= 1'b0;
      max_entries_q <= MAX_ENTRIES_RESET;
    end else begin
      item_valid_q <= item_valid_d;
      out_valid_q  <= out_valid_d;
      entries_q    <= entries_d;
      done_q       <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        max_entries_q <= cfg_data_i;
      end
    end
  end

  // Payload registers load only on their handshake and carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_item_i;
    end
    if (stage_fire && dec.emit) begin
      out_item_q <= dec.result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // A delivered result closes the search until the next start.
  `ASSERT_NEXT(a_result_closes_search, clk_i, rst_ni, stage_fire && dec.emit, done_q,
               "result issued but search not marked done")

  // A start clears the scan count and reopens the search.
  `ASSERT_NEXT(a_start_reopens, clk_i, rst_ni, stage_fire && (item_q.op == OP_START),
               (entries_q == 16'd0) && !done_q, "start did not clear search state")

  // Within a search the scan count never moves backward.
  `ASSERT_NEXT(a_count_monotonic, clk_i, rst_ni,
               !(stage_fire && (item_q.op == OP_START)), entries_q >= $past(entries_q),
               "entry count decreased without a start")

endmodule
